FILE: design/ssc_pkg.sv
// ----------------------------------------------------------------------------
// ssc_pkg
// types and constants shared by the replacement unit's modules
// ----------------------------------------------------------------------------
package ssc_pkg;

    localparam int ADDR_W   = 48;
    localparam int DELTA_W  = 49;
    localparam int SETIN_W  = 11;
    localparam int WAYIN_W  = 4;
    localparam int MASK_W   = 16;
    localparam int CNT_W    = 2;
    localparam int SIG_SHIFT   = 2;
    localparam int GROUP_SHIFT = 6;
    localparam int RECIP_SHIFT = 24;

    localparam logic [1:0] RRPV_MAX = 2'd3;
    localparam logic [1:0] CNT_MAX  = 2'd3;

    localparam logic [1:0] CFG_STREAM_THR = 2'd0;
    localparam logic [1:0] CFG_REUSE_THR  = 2'd1;

    localparam logic CMD_QUERY  = 1'b0;
    localparam logic CMD_UPDATE = 1'b1;

    typedef struct packed {
        logic                 cmd;
        logic [SETIN_W-1:0]   set_index;
        logic [SETIN_W-1:0]   quot;
        logic [WAYIN_W-1:0]   way_index;
        logic [ADDR_W-1:0]    phys_addr;
        logic [ADDR_W-1:0]    pc;
        logic [ADDR_W-1:0]    evict_addr;
        logic                 hit;
        logic [MASK_W-1:0]    valid_mask;
    } t_item;

    typedef struct packed {
        logic [1:0] stream_thr;
        logic [1:0] reuse_thr;
    } t_cfg;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDX,
        ST_RD1,
        ST_RD2,
        ST_EXEC
    } t_state;

endpackage

FILE: design/ssc_ram.sv
// ----------------------------------------------------------------------------
// ssc_ram
// generic simple dual-port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module ssc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                      i_wdata,
    input  logic                                  i_re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                      o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: design/ssc_front.sv
// ----------------------------------------------------------------------------
// ssc_front
// input queue, takes transfers and precomputes the set quotient
// ----------------------------------------------------------------------------
module ssc_front
    import ssc_pkg::*;
#(
    parameter int NUM_SETS = 2048
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic                  i_cmd,
    input  logic [SETIN_W-1:0]    i_set_index,
    input  logic [WAYIN_W-1:0]    i_way_index,
    input  logic [ADDR_W-1:0]     i_phys_addr,
    input  logic [ADDR_W-1:0]     i_pc,
    input  logic [ADDR_W-1:0]     i_evict_addr,
    input  logic                  i_hit,
    input  logic [MASK_W-1:0]     i_valid_mask,
    output logic                  o_head_valid,
    output t_item                 o_head,
    input  logic                  i_pop
);

    localparam logic [RECIP_SHIFT:0] RECIP = (RECIP_SHIFT+1)'((64'd1 << RECIP_SHIFT) / NUM_SETS);
    localparam int PROD_W = SETIN_W + RECIP_SHIFT + 1;

    t_item             r_q [2];
    logic              r_wr_ptr, r_rd_ptr;
    logic [1:0]        r_cnt;
    logic [PROD_W-1:0] w_prod;
    logic              w_push;
    t_item             w_item;

    // quotient may fall one short, the back end corrects
    assign w_prod = PROD_W'(i_set_index) * PROD_W'(RECIP);
    assign w_push = i_in_valid && o_in_ready;

    always_comb begin
        w_item.cmd         = i_cmd;
        w_item.set_index   = i_set_index;
        w_item.quot        = w_prod[RECIP_SHIFT +: SETIN_W];
        w_item.way_index   = i_way_index;
        w_item.phys_addr   = i_phys_addr;
        w_item.pc          = i_pc;
        w_item.evict_addr  = i_evict_addr;
        w_item.hit         = i_hit;
        w_item.valid_mask  = i_valid_mask;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_cnt    <= 2'd0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            r_cnt <= r_cnt + 2'(w_push) - 2'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wr_ptr] <= w_item;
        end
    end

    assign o_in_ready   = (r_cnt != 2'd2);
    assign o_head_valid = (r_cnt != 2'd0);
    assign o_head       = r_q[r_rd_ptr];

endmodule

FILE: design/ssc_back.sv
// ----------------------------------------------------------------------------
// ssc_back
// per-item read-modify-write of set row and reuse tables, result register
// ----------------------------------------------------------------------------
module ssc_back
    import ssc_pkg::*;
#(
    parameter int NUM_SETS   = 2048,
    parameter int NUM_WAYS   = 16,
    parameter int SIG_BITS   = 5,
    parameter int GROUP_BITS = 12
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cfg               i_cfg,
    input  logic               i_head_valid,
    input  t_item              i_head,
    output logic               o_pop,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [WAYIN_W-1:0] o_victim_way,
    output logic               o_streaming
);

    localparam int SET_W   = NUM_SETS > 1 ? $clog2(NUM_SETS) : 1;
    localparam int SIG_N   = 1 << SIG_BITS;
    localparam int GROUP_N = 1 << GROUP_BITS;
    localparam int CLR_A   = NUM_SETS > SIG_N ? NUM_SETS : SIG_N;
    localparam int CLR_N   = CLR_A > GROUP_N ? CLR_A : GROUP_N;
    localparam int CLR_W   = $clog2(CLR_N + 1);
    localparam int RRPV_W  = 2 * NUM_WAYS;
    localparam int ROW_W   = RRPV_W + CNT_W + DELTA_W + ADDR_W;
    localparam int QP_W    = SETIN_W + 17;
    localparam int CHK_W   = NUM_WAYS < MASK_W ? NUM_WAYS : MASK_W;

    t_state              r_state, n_state;
    logic [CLR_W-1:0]    r_clr;
    logic [SET_W-1:0]    r_set;
    logic [CNT_W-1:0]    r_gr_val;
    logic                r_out_valid;
    logic [WAYIN_W-1:0]  r_victim;
    logic                r_stream;

    // ram controls
    logic                set_we, set_re;
    logic [SET_W-1:0]    set_waddr;
    logic [ROW_W-1:0]    set_wdata, set_rdata;
    logic                sig_we, sig_re;
    logic [SIG_BITS-1:0] sig_waddr, sig_raddr;
    logic [CNT_W-1:0]    sig_wdata, sig_rdata;
    logic                grp_we, grp_re;
    logic [GROUP_BITS-1:0] grp_waddr, grp_raddr;
    logic [CNT_W-1:0]    grp_wdata, grp_rdata;

    logic                clr_last, exec_fire;
    logic [16:0]         rem;
    logic [QP_W-1:0]     qprod;

    // execute datapath
    logic [RRPV_W-1:0]   row_rrpv, new_rrpv;
    logic [CNT_W-1:0]    row_cnt, new_cnt;
    logic [DELTA_W-1:0]  row_delta, delta;
    logic [ADDR_W-1:0]   row_addr;
    logic                str, wok, reuse, found;
    logic [1:0]          maxv, new_val;
    logic [WAYIN_W-1:0]  victim;
    logic [SIG_BITS-1:0]   sg;
    logic [GROUP_BITS-1:0] gr, vg;

    ssc_ram #(.WIDTH(ROW_W), .DEPTH(NUM_SETS)) u_set_ram (
        .i_clk   (i_clk),
        .i_we    (set_we),
        .i_waddr (set_waddr),
        .i_wdata (set_wdata),
        .i_re    (set_re),
        .i_raddr (r_set),
        .o_rdata (set_rdata)
    );

    ssc_ram #(.WIDTH(CNT_W), .DEPTH(SIG_N)) u_sig_ram (
        .i_clk   (i_clk),
        .i_we    (sig_we),
        .i_waddr (sig_waddr),
        .i_wdata (sig_wdata),
        .i_re    (sig_re),
        .i_raddr (sig_raddr),
        .o_rdata (sig_rdata)
    );

    ssc_ram #(.WIDTH(CNT_W), .DEPTH(GROUP_N)) u_grp_ram (
        .i_clk   (i_clk),
        .i_we    (grp_we),
        .i_waddr (grp_waddr),
        .i_wdata (grp_wdata),
        .i_re    (grp_re),
        .i_raddr (grp_raddr),
        .o_rdata (grp_rdata)
    );

    assign sg = i_head.pc[SIG_SHIFT +: SIG_BITS];
    assign gr = i_head.phys_addr[GROUP_SHIFT +: GROUP_BITS];
    assign vg = i_head.evict_addr[GROUP_SHIFT +: GROUP_BITS];

    assign clr_last  = (r_clr == CLR_W'(CLR_N - 1));
    assign exec_fire = (r_state == ST_EXEC) && (!r_out_valid || i_out_ready);

    // set index modulo the set count, one correction step
    always_comb begin
        qprod = QP_W'(i_head.quot) * QP_W'(NUM_SETS);
        rem   = 17'(QP_W'(i_head.set_index) - qprod);
        if (rem >= 17'(NUM_SETS)) begin
            rem = rem - 17'(NUM_SETS);
        end
    end

    // stream detector and replacement decision
    always_comb begin
        row_rrpv  = set_rdata[RRPV_W-1:0];
        row_cnt   = set_rdata[RRPV_W +: CNT_W];
        row_delta = set_rdata[RRPV_W + CNT_W +: DELTA_W];
        row_addr  = set_rdata[RRPV_W + CNT_W + DELTA_W +: ADDR_W];
        delta     = {1'b0, i_head.phys_addr} - {1'b0, row_addr};
        new_cnt   = row_cnt;
        str       = 1'b0;
        if (row_addr != '0) begin
            if (delta == row_delta && delta != '0) begin
                if (row_cnt != CNT_MAX) begin
                    new_cnt = row_cnt + 2'd1;
                end
            end else if (row_cnt != 2'd0) begin
                new_cnt = row_cnt - 2'd1;
            end
            str = (new_cnt >= i_cfg.stream_thr);
        end

        // largest rrpv present in the row
        maxv = 2'd0;
        for (int w = 0; w < NUM_WAYS; w++) begin
            if (row_rrpv[2*w +: 2] > maxv) begin
                maxv = row_rrpv[2*w +: 2];
            end
        end

        victim = '0;
        for (int w = NUM_WAYS - 1; w >= 0; w--) begin
            if (row_rrpv[2*w +: 2] == maxv) begin
                victim = WAYIN_W'(w);
            end
        end
        found = 1'b0;
        if (str) begin
            for (int w = CHK_W - 1; w >= 0; w--) begin
                if (!i_head.valid_mask[w]) begin
                    victim = WAYIN_W'(w);
                    found  = 1'b1;
                end
            end
        end
        if (i_head.cmd == CMD_UPDATE) begin
            victim = '0;
        end

        reuse = (sig_rdata >= i_cfg.reuse_thr) || (r_gr_val >= i_cfg.reuse_thr);
        if (i_head.hit) begin
            new_val = 2'd0;
        end else if (str) begin
            new_val = RRPV_MAX;
        end else begin
            new_val = reuse ? 2'd0 : RRPV_MAX;
        end
        wok = ({2'b00, i_head.way_index} < 6'(NUM_WAYS));
        new_rrpv = row_rrpv;
        for (int w = 0; w < NUM_WAYS; w++) begin
            if (i_head.cmd == CMD_UPDATE && wok && i_head.way_index == WAYIN_W'(w)) begin
                new_rrpv[2*w +: 2] = new_val;
            end
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR: if (clr_last) n_state = ST_IDX;
            ST_IDX:   if (i_head_valid) n_state = ST_RD1;
            ST_RD1:   n_state = ST_RD2;
            ST_RD2:   n_state = ST_EXEC;
            ST_EXEC:  if (exec_fire) n_state = ST_IDX;
            default:  n_state = ST_CLEAR;
        endcase
    end

    // ram controls
    always_comb begin
        set_we    = 1'b0;
        set_re    = 1'b0;
        set_waddr = r_set;
        set_wdata = {i_head.phys_addr, delta, new_cnt, new_rrpv};
        sig_we    = 1'b0;
        sig_re    = 1'b0;
        sig_waddr = sg;
        sig_raddr = sg;
        sig_wdata = sig_rdata;
        grp_we    = 1'b0;
        grp_re    = 1'b0;
        grp_waddr = gr;
        grp_raddr = gr;
        grp_wdata = r_gr_val;
        o_pop     = 1'b0;
        case (r_state)
            ST_CLEAR: begin
                set_we    = (r_clr < CLR_W'(NUM_SETS));
                set_waddr = SET_W'(r_clr);
                set_wdata = {{(ROW_W-RRPV_W){1'b0}}, {RRPV_W{1'b1}}};
                sig_we    = (r_clr < CLR_W'(SIG_N));
                sig_waddr = SIG_BITS'(r_clr);
                sig_wdata = '0;
                grp_we    = (r_clr < CLR_W'(GROUP_N));
                grp_waddr = GROUP_BITS'(r_clr);
                grp_wdata = '0;
            end
            ST_RD1: begin
                set_re = 1'b1;
                sig_re = 1'b1;
                grp_re = 1'b1;
            end
            ST_RD2: begin
                grp_re    = 1'b1;
                grp_raddr = vg;
            end
            ST_EXEC: begin
                set_we = exec_fire;
                o_pop  = exec_fire;
                if (i_head.cmd == CMD_UPDATE) begin
                    if (i_head.hit) begin
                        sig_we    = exec_fire;
                        sig_wdata = (sig_rdata == CNT_MAX) ? sig_rdata : sig_rdata + 2'd1;
                        grp_we    = exec_fire;
                        grp_waddr = gr;
                        grp_wdata = (r_gr_val == CNT_MAX) ? r_gr_val : r_gr_val + 2'd1;
                    end else if (!str) begin
                        sig_we    = exec_fire;
                        sig_wdata = (sig_rdata == 2'd0) ? sig_rdata : sig_rdata - 2'd1;
                        grp_we    = exec_fire;
                        grp_waddr = vg;
                        grp_wdata = (grp_rdata == 2'd0) ? grp_rdata : grp_rdata - 2'd1;
                    end
                end
            end
            default: begin
                o_pop = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_CLEAR) begin
                r_clr <= r_clr + CLR_W'(1);
            end
            if (exec_fire) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDX) begin
            r_set <= SET_W'(rem);
        end
        if (r_state == ST_RD2) begin
            r_gr_val <= grp_rdata;
        end
        if (exec_fire) begin
            r_victim <= victim;
            r_stream <= str;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_victim_way = r_victim;
    assign o_streaming  = r_stream;

endmodule

FILE: design/ship_stream_cache_replacement.sv
// ----------------------------------------------------------------------------
// ship_stream_cache_replacement
// rrip replacement unit with signature and address-group reuse prediction
// ----------------------------------------------------------------------------
// steps: index, 2 reads, execute; execute waits while the last result is unaccepted
// items: the back end's row read-modify-write ends before it takes the next item
// reset: synchronous, active low; then a clearing pass over max(NUM_SETS,
//   2**GROUP_BITS, 2**SIG_BITS) table entries before items are processed
module ship_stream_cache_replacement
    import ssc_pkg::*;
#(
    parameter int NUM_SETS   = 2048,
    parameter int NUM_WAYS   = 16,
    parameter int SIG_BITS   = 5,
    parameter int GROUP_BITS = 12
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic               i_cmd,
    input  logic [SETIN_W-1:0] i_set_index,
    input  logic [WAYIN_W-1:0] i_way_index,
    input  logic [ADDR_W-1:0]  i_phys_addr,
    input  logic [ADDR_W-1:0]  i_pc,
    input  logic [ADDR_W-1:0]  i_evict_addr,
    input  logic               i_hit,
    input  logic [MASK_W-1:0]  i_valid_mask,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [WAYIN_W-1:0] o_victim_way,
    output logic               o_streaming,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [1:0]         i_cfg_index,
    input  logic [1:0]         i_cfg_data
);

    t_cfg  r_cfg;
    logic  head_valid, pop;
    t_item head;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.stream_thr <= 2'd2;
            r_cfg.reuse_thr  <= 2'd2;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_STREAM_THR: r_cfg.stream_thr <= i_cfg_data;
                CFG_REUSE_THR:  r_cfg.reuse_thr  <= i_cfg_data;
                default:        r_cfg <= r_cfg;
            endcase
        end
    end

    assign o_cfg_ready = 1'b1;

    ssc_front #(.NUM_SETS(NUM_SETS)) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_cmd         (i_cmd),
        .i_set_index   (i_set_index),
        .i_way_index   (i_way_index),
        .i_phys_addr   (i_phys_addr),
        .i_pc          (i_pc),
        .i_evict_addr  (i_evict_addr),
        .i_hit         (i_hit),
        .i_valid_mask  (i_valid_mask),
        .o_head_valid  (head_valid),
        .o_head        (head),
        .i_pop         (pop)
    );

    ssc_back #(
        .NUM_SETS   (NUM_SETS),
        .NUM_WAYS   (NUM_WAYS),
        .SIG_BITS   (SIG_BITS),
        .GROUP_BITS (GROUP_BITS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_head_valid (head_valid),
        .i_head       (head),
        .o_pop        (pop),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_victim_way (o_victim_way),
        .o_streaming  (o_streaming)
    );

endmodule
